/* hw/rtl/bbsa_pkg.sv */
// Shared types and constants of the balanced base-255 serial adder.
package bbsa_pkg;

   // Digit range and radix on the widened sum
   localparam logic signed [9:0] SUM_HI = 10'sd127;
   localparam logic signed [9:0] SUM_LO = -10'sd127;
   localparam logic signed [9:0] RADIX  = 10'sd255;

   // Longest zero run that one word can carry
   localparam logic [7:0] RUN_MAX = 8'd255;

   // Most words that one item can produce
   localparam int WORDS_PER_ITEM = 3;

   typedef struct packed {
      logic [7:0]        zeros_before;
      logic signed [7:0] sum_digit;
      logic              end_marker;
   } result_type;

   // All words produced by one item, entry 0 first
   typedef struct packed {
      logic [1:0]                            count;
      result_type [WORDS_PER_ITEM-1:0]       entries;
   } bundle_type;

   // Front to queue
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } qpush_type;

   // Queue head to back
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } qhead_type;

endpackage

/* hw/rtl/bbsa_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
interface bbsa_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] digit_a;
   logic signed [7:0] digit_b;
   logic              final_position;

   modport source (output valid, output digit_a, output digit_b, output final_position,
                   input ready);
   modport sink   (input valid, input digit_a, input digit_b, input final_position,
                   output ready);
endinterface

interface bbsa_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        zeros_before;
   logic signed [7:0] sum_digit;
   logic              end_marker;

   modport source (output valid, output zeros_before, output sum_digit, output end_marker,
                   input ready);
   modport sink   (input valid, input zeros_before, input sum_digit, input end_marker,
                   output ready);
endinterface

/* hw/rtl/bbsa_front.sv */
// Front end: accepts digit pairs, reduces the sum and builds the word bundle.
module bbsa_front (
   input  logic                 clock,
   input  logic                 reset,
   bbsa_req_if.sink             req_ch,
   input  logic                 queue_ready,
   output bbsa_pkg::qpush_type  push
);

   logic signed [1:0] carry_ff, carry_in;
   logic [7:0]        run_ff, run_in;

   logic signed [9:0] sum_w;
   logic signed [7:0] digit_w;
   logic signed [1:0] carry_new;
   logic [7:0]        run_mid;
   logic [1:0]        n_w;
   logic              accept_w;
   bbsa_pkg::bundle_type bundle_w;

   assign req_ch.ready = queue_ready;
   assign accept_w     = req_ch.valid && queue_ready;

   // Reduce carry + a + b to a balanced digit and a new carry
   always_comb begin
      sum_w = 10'(req_ch.digit_a) + 10'(req_ch.digit_b) + 10'(carry_ff);
      if (sum_w > bbsa_pkg::SUM_HI) begin
         digit_w   = 8'(sum_w - bbsa_pkg::RADIX);
         carry_new = 2'sd1;
      end else if (sum_w < bbsa_pkg::SUM_LO) begin
         digit_w   = 8'(sum_w + bbsa_pkg::RADIX);
         carry_new = -2'sd1;
      end else begin
         digit_w   = 8'(sum_w);
         carry_new = 2'sd0;
      end
   end

   // Build the words of this item and the next carry and run
   always_comb begin
      bundle_w = '0;
      n_w      = 2'd0;
      run_mid  = run_ff;
      if (digit_w == 8'sd0) begin
         if (run_ff == bbsa_pkg::RUN_MAX) begin
            bundle_w.entries[n_w] = '{zeros_before: bbsa_pkg::RUN_MAX,
                                      sum_digit: 8'sd0, end_marker: 1'b0};
            n_w     = n_w + 2'd1;
            run_mid = 8'd0;
         end else begin
            run_mid = run_ff + 8'd1;
         end
      end else begin
         bundle_w.entries[n_w] = '{zeros_before: run_ff, sum_digit: digit_w,
                                   end_marker: 1'b0};
         n_w     = n_w + 2'd1;
         run_mid = 8'd0;
      end

      run_in   = run_mid;
      carry_in = carry_new;
      if (req_ch.final_position) begin
         // Flush the leftover carry, then close the number
         if (carry_new != 2'sd0) begin
            bundle_w.entries[n_w] = '{zeros_before: run_mid, sum_digit: 8'(carry_new),
                                      end_marker: 1'b0};
            n_w = n_w + 2'd1;
         end
         bundle_w.entries[n_w] = '{zeros_before: 8'd0, sum_digit: 8'sd0,
                                   end_marker: 1'b1};
         n_w      = n_w + 2'd1;
         run_in   = 8'd0;
         carry_in = 2'sd0;
      end
      bundle_w.count = n_w;
   end

   assign push.valid  = accept_w && (n_w != 2'd0);
   assign push.bundle = bundle_w;

   // Advance carry and zero run on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 2'sd0;
         run_ff   <= 8'd0;
      end else if (accept_w) begin
         carry_ff <= carry_in;
         run_ff   <= run_in;
      end
   end

endmodule

/* hw/rtl/bbsa_queue.sv */
// Short queue of word bundles between front and back.
module bbsa_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bbsa_pkg::qpush_type  push,
   output logic                 ready,
   output bbsa_pkg::qhead_type  head,
   input  logic                 pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bbsa_pkg::bundle_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign ready       = (cnt_ff != CNT_FULL);
   assign head.valid  = (cnt_ff != '0);
   assign head.bundle = slot_ff[rd_ptr_ff];
   assign do_push     = push.valid && ready;
   assign do_pop      = pop && head.valid;

   // Step pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.bundle;
      end
   end

endmodule

/* hw/rtl/bbsa_back.sv */
// Back end: unpacks bundles and presents one word per cycle on the output while the receiver is ready.
module bbsa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bbsa_pkg::qhead_type  head,
   output logic                 pop,
   bbsa_rsp_if.source           rsp_ch
);

   bbsa_pkg::bundle_type cur_ff, cur_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 busy_ff, busy_in;
   logic                 out_valid_ff, out_valid_in;
   bbsa_pkg::result_type out_ff, out_in;
   logic                 out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Load the next word from the open bundle, else from the queue head
   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pop          = 1'b0;
      if (out_free) begin
         if (busy_ff) begin
            out_in       = cur_ff.entries[idx_ff];
            out_valid_in = 1'b1;
            idx_in       = idx_ff + 2'd1;
            busy_in      = (idx_ff + 2'd1) != cur_ff.count;
         end else if (head.valid) begin
            pop          = 1'b1;
            out_in       = head.bundle.entries[0];
            out_valid_in = 1'b1;
            cur_in       = head.bundle;
            idx_in       = 2'd1;
            busy_in      = head.bundle.count != 2'd1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.zeros_before = out_ff.zeros_before;
   assign rsp_ch.sum_digit    = out_ff.sum_digit;
   assign rsp_ch.end_marker   = out_ff.end_marker;

endmodule

/* hw/rtl/balanced_base255_serial_adder_top.sv */
// Top level of the balanced base-255 serial adder.
// Adds two balanced base-255 numbers one digit position per request word, least
// significant first. The front end takes a request word in any cycle in which the
// bundle queue (QUEUE_DEPTH entries) has room and turns it into zero to three
// response words: zero digits are counted and sent as a zeros_before count with the
// next nonzero digit, and a final position adds the carry digit and an end marker.
// The back end sends one response word per cycle from a registered output while the
// response port is ready, so a slow receiver fills the queue and holds off new request
// words. The first word of a request passes through the bundle queue and then the back
// end's output register before it is valid on the response port.
module balanced_base255_serial_adder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   bbsa_req_if.sink    req_ch,
   bbsa_rsp_if.source  rsp_ch
);

   bbsa_pkg::qpush_type push;
   bbsa_pkg::qhead_type head;
   logic                queue_ready;
   logic                pop;

   bbsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .queue_ready (queue_ready),
      .push        (push)
   );

   bbsa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .ready (queue_ready),
      .head  (head),
      .pop   (pop)
   );

   bbsa_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

/* dv/tb_balanced_base255_serial_adder_top.sv */
// Testbench for the balanced base-255 serial adder: directed table, random numbers, checker.
module tb_balanced_base255_serial_adder_top;

   // Consecutive cycles with no word moving on either side before the run is abandoned
   localparam int STALL_LIMIT      = 4000;
   localparam int RANDOM_POSITIONS = 150;
   localparam int DRAIN_CYCLES     = 8;

   // One request position, with optional hand-written expected words
   typedef struct packed {
      logic signed [7:0]              digit_a;
      logic signed [7:0]              digit_b;
      logic                           final_position;
      logic                           typed;
      logic [1:0]                     count;
      bbsa_pkg::result_type [2:0]     words;
   } position_row_type;

   logic clock;
   logic reset;

   bbsa_req_if req_bus ();
   bbsa_rsp_if rsp_bus ();

   balanced_base255_serial_adder_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Adder state as the testbench sees it
   logic signed [1:0] carry_state;
   logic [7:0]        zero_run_state;

   bbsa_pkg::result_type sum_words[$];
   bbsa_pkg::result_type step_words[$];
   position_row_type     directed_rows[$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int fail_count;
   int positions_sent;
   int numbers_sent;
   int words_checked;
   int quiet_cycles;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bbsa_pkg::result_type make_word(input logic [7:0] zeros,
                                                      input logic signed [7:0] d,
                                                      input logic e);
      bbsa_pkg::result_type w;
      w.zeros_before = zeros;
      w.sum_digit    = d;
      w.end_marker   = e;
      return w;
   endfunction

   function automatic position_row_type make_row(input logic signed [7:0] a,
                                                 input logic signed [7:0] b, input logic fin);
      position_row_type r;
      r = '0;
      r.digit_a        = a;
      r.digit_b        = b;
      r.final_position = fin;
      return r;
   endfunction

   // Count a zero digit into the run, or send a nonzero digit with the run ahead of it
   task automatic place_digit(input logic signed [7:0] d);
      if (d == 8'sd0) begin
         if (zero_run_state == bbsa_pkg::RUN_MAX) begin
            step_words.push_back(make_word(bbsa_pkg::RUN_MAX, 8'sd0, 1'b0));
            zero_run_state = 8'd0;
         end else begin
            zero_run_state = zero_run_state + 8'd1;
         end
      end else begin
         step_words.push_back(make_word(zero_run_state, d, 1'b0));
         zero_run_state = 8'd0;
      end
   endtask

   // Advance the adder by one position; the words it causes land in step_words
   task automatic add_position(input logic signed [7:0] a, input logic signed [7:0] b,
                               input logic fin);
      int total;
      int reduced;
      step_words.delete();
      total = int'(carry_state) + int'(a) + int'(b);
      if (total > int'(bbsa_pkg::SUM_HI)) begin
         reduced     = total - int'(bbsa_pkg::RADIX);
         carry_state = 2'sd1;
      end else if (total < int'(bbsa_pkg::SUM_LO)) begin
         reduced     = total + int'(bbsa_pkg::RADIX);
         carry_state = -2'sd1;
      end else begin
         reduced     = total;
         carry_state = 2'sd0;
      end
      place_digit(reduced[7:0]);
      if (fin) begin
         if (carry_state != 2'sd0) begin
            place_digit(8'(int'(carry_state)));
         end
         step_words.push_back(make_word(8'd0, 8'sd0, 1'b1));
         zero_run_state = 8'd0;
         carry_state    = 2'sd0;
      end
   endtask

   // Present one position, hold it until taken, then book its expected words
   task automatic send_position(input position_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.digit_a        <= row.digit_a;
      req_bus.digit_b        <= row.digit_b;
      req_bus.final_position <= row.final_position;
      do @(posedge clock); while (!req_bus.ready);
      add_position(row.digit_a, row.digit_b, row.final_position);
      if (row.typed) begin
         for (int i = 0; i < int'(row.count); i++) sum_words.push_back(row.words[i]);
      end else begin
         foreach (step_words[i]) sum_words.push_back(step_words[i]);
      end
      positions_sent++;
      if (row.final_position) numbers_sent++;
   endtask

   task automatic table_row(input logic signed [7:0] a, input logic signed [7:0] b,
                            input logic fin, input int n, input bbsa_pkg::result_type w0,
                            input bbsa_pkg::result_type w1, input bbsa_pkg::result_type w2);
      position_row_type r;
      r          = make_row(a, b, fin);
      r.typed    = 1'b1;
      r.count    = 2'(n);
      r.words[0] = w0;
      r.words[1] = w1;
      r.words[2] = w2;
      directed_rows.push_back(r);
   endtask

   // Digit mix weighted toward zeros and the range ends, with the odd -128
   function automatic logic signed [7:0] pick_digit();
      case ($urandom_range(9))
         0, 1, 2: return 8'sd0;
         3:       return 8'sd127;
         4:       return -8'sd127;
         5:       return 8'($signed($urandom_range(6)) - 3);
         9:       return ($urandom_range(1) != 0) ? 8'sh80 : 8'($urandom_range(254) - 127);
         default: return 8'($urandom_range(254) - 127);
      endcase
   endfunction

   // Send one well-formed number pair; the shorter operand pads with zeros
   task automatic send_number();
      int len_a;
      int len_b;
      int len;
      logic signed [7:0] a;
      logic signed [7:0] b;
      len_a = $urandom_range(1, 8);
      len_b = $urandom_range(1, 8);
      len   = (len_a > len_b) ? len_a : len_b;
      for (int i = 0; i < len; i++) begin
         a = (i < len_a) ? pick_digit() : 8'sd0;
         b = (i < len_b) ? pick_digit() : 8'sd0;
         send_position(make_row(a, b, i == len - 1));
      end
   endtask

   // Check each response word against the oldest expectation; pace ready
   always @(posedge clock) begin
      bbsa_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (sum_words.size() == 0) begin
            $error("unexpected word: zeros_before %0d sum_digit %0d end_marker %0d",
                   rsp_bus.zeros_before, rsp_bus.sum_digit, rsp_bus.end_marker);
            fail_count++;
         end else begin
            want = sum_words.pop_front();
            if (rsp_bus.zeros_before !== want.zeros_before) begin
               $error("zeros_before: expected %0d, actual %0d",
                      want.zeros_before, rsp_bus.zeros_before);
               fail_count++;
            end
            if (rsp_bus.sum_digit !== want.sum_digit) begin
               $error("sum_digit: expected %0d, actual %0d", want.sum_digit, rsp_bus.sum_digit);
               fail_count++;
            end
            if (rsp_bus.end_marker !== want.end_marker) begin
               $error("end_marker: expected %0d, actual %0d",
                      want.end_marker, rsp_bus.end_marker);
               fail_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Abandon the run if no word moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bbsa_pkg::result_type none;
      int random_start;
      none                   = make_word(8'd0, 8'sd0, 1'b0);
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.digit_a        = 8'sd0;
      req_bus.digit_b        = 8'sd0;
      req_bus.final_position = 1'b0;
      rsp_bus.ready          = 1'b0;
      sender_idle_pct        = 0;
      receiver_stall_pct     = 0;
      fail_count             = 0;
      positions_sent         = 0;
      numbers_sent           = 0;
      words_checked          = 0;
      quiet_cycles           = 0;
      carry_state            = 2'sd0;
      zero_run_state         = 8'd0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Zero sum, extreme digits with carry out, the out-of-range -128, zero runs
      table_row(0, 0, 1, 1, make_word(0, 0, 1), none, none);
      table_row(127, 127, 1, 3, make_word(0, -1, 0), make_word(0, 1, 0), make_word(0, 0, 1));
      table_row(-127, -127, 1, 3, make_word(0, 1, 0), make_word(0, -1, 0), make_word(0, 0, 1));
      table_row(-128, -128, 1, 3, make_word(0, -1, 0), make_word(0, -1, 0), make_word(0, 0, 1));
      table_row(127, 0, 0, 1, make_word(0, 127, 0), none, none);
      table_row(0, 0, 0, 0, none, none, none);
      table_row(0, 0, 0, 0, none, none, none);
      table_row(5, -3, 0, 1, make_word(2, 2, 0), none, none);
      table_row(0, 0, 1, 1, make_word(0, 0, 1), none, none);
      table_row(127, 1, 0, 1, make_word(0, -127, 0), none, none);
      table_row(0, 0, 1, 2, make_word(0, 1, 0), make_word(0, 0, 1), none);
      table_row(-128, 127, 0, 1, make_word(0, -1, 0), none, none);
      table_row(100, 100, 0, 1, make_word(0, -55, 0), none, none);
      table_row(127, -1, 1, 2, make_word(0, 127, 0), make_word(0, 0, 1), none);
      table_row(-127, 0, 0, 1, make_word(0, -127, 0), none, none);
      table_row(-1, -127, 0, 1, make_word(0, 127, 0), none, none);
      table_row(-127, 1, 1, 2, make_word(0, -127, 0), make_word(0, 0, 1), none);
      // Zero digit on the top position while a carry is pending
      directed_rows.push_back(make_row(8'sd1, 8'sd0, 1'b0));
      directed_rows.push_back(make_row(8'sd0, 8'sd0, 1'b0));
      directed_rows.push_back(make_row(8'sd127, 8'sd127, 1'b0));
      directed_rows.push_back(make_row(8'sd127, 8'sd127, 1'b1));
      directed_rows.push_back(make_row(-8'sd127, -8'sd127, 1'b0));
      directed_rows.push_back(make_row(-8'sd127, -8'sd127, 1'b1));
      foreach (directed_rows[i]) send_position(directed_rows[i]);

      // Random numbers over four pacing phases, with some loose noise positions
      random_start = positions_sent;
      while (positions_sent - random_start < RANDOM_POSITIONS) begin
         case ((positions_sent - random_start) * 4 / RANDOM_POSITIONS)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         if ($urandom_range(99) < 15) begin
            send_position(make_row(8'($urandom), 8'($urandom), $urandom_range(3) == 0));
         end else begin
            send_number();
         end
      end
      req_bus.valid <= 1'b0;

      // Drain the remaining words, then watch for strays
      while (sum_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d positions forming %0d numbers; checked %0d result words",
               positions_sent, numbers_sent, words_checked);
      $display("Pacing covered free flow, idle sender, stalled receiver and both at once");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
